>>> rtl/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants for the prefix function stream.
// Holds the string capacity, derived widths, state codes and result record.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int POS_W      = ADDR_W + 1;
  localparam int SYM_W      = 8;
  localparam int PLEN_W     = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  typedef struct packed {
    logic [PLEN_W-1:0] prefix_len;
    logic              overflow;
  } pfs_res_t;

endpackage

>>> rtl/pfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_ram: generic simple dual-port RAM.
// One write port and one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_core: prefix function engine.
// Keeps the symbols and prefix values of the current string in two RAMs and
// walks the fallback chain one memory read per cycle.
// ----------------------------------------------------------------------------
module pfs_core
  import pfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sym_t     in_symbol,
  input  logic     in_start,
  output logic     res_valid,
  input  logic     res_take,
  output pfs_res_t res
);

  state_t state;
  pos_t   position;
  addr_t  prev_len;
  addr_t  len;
  sym_t   sym;

  logic   accept;
  pos_t   eff_pos;
  logic   is_ovf;
  logic   is_first;
  logic   match;
  logic   cmp_done;
  addr_t  len_final;

  logic   rd_en;
  addr_t  rd_sym_addr;
  addr_t  rd_pre_addr;
  sym_t   sym_rd;
  addr_t  pre_rd;

  logic   wr_en;
  addr_t  wr_addr;
  sym_t   wr_sym;
  addr_t  wr_len;

  logic   res_set;
  addr_t  res_len;
  logic   res_ovf;

  always_comb begin
    in_ready  = (state == S_IDLE) && (!res_valid || res_take);
    accept    = in_valid && in_ready;
    eff_pos   = in_start ? '0 : position;
    is_ovf    = (eff_pos == POS_W'(MAX_LEN));
    is_first  = (eff_pos == '0);
    match     = (sym == sym_rd);
    cmp_done  = (state == S_CMP) && (match || (len == '0));
    len_final = match ? (len + 1'b1) : '0;

    rd_en       = 1'b0;
    rd_sym_addr = prev_len;
    rd_pre_addr = prev_len - 1'b1;
    if (accept && !is_ovf && !is_first) begin
      rd_en = 1'b1;
    end else if ((state == S_CMP) && !cmp_done) begin
      // Mismatch with a nonzero length: fall back to the stored prefix value.
      rd_en       = 1'b1;
      rd_sym_addr = pre_rd;
      rd_pre_addr = pre_rd - 1'b1;
    end

    wr_en   = 1'b0;
    wr_addr = position[ADDR_W-1:0];
    wr_sym  = sym;
    wr_len  = len_final;
    res_set = 1'b0;
    res_len = len_final;
    res_ovf = 1'b0;
    if (accept && is_ovf) begin
      res_set = 1'b1;
      res_len = '0;
      res_ovf = 1'b1;
    end else if (accept && is_first) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_sym  = in_symbol;
      wr_len  = '0;
      res_set = 1'b1;
      res_len = '0;
    end else if (cmp_done) begin
      wr_en   = 1'b1;
      res_set = 1'b1;
    end
  end

  pfs_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_LEN)
  ) u_sym_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_sym),
    .rd_en   (rd_en),
    .rd_addr (rd_sym_addr),
    .rd_data (sym_rd)
  );

  pfs_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(MAX_LEN)
  ) u_pre_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_len),
    .rd_en   (rd_en),
    .rd_addr (rd_pre_addr),
    .rd_data (pre_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && !is_ovf) begin
            if (is_first) begin
              position <= pos_t'(1);
            end else begin
              position <= eff_pos;
              state    <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (cmp_done) begin
            position <= position + 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res.prefix_len <= PLEN_W'(res_len);
      res.overflow   <= res_ovf;
    end
    if (accept && is_first) begin
      prev_len <= '0;
    end else if (cmp_done) begin
      prev_len <= len_final;
    end
    if (accept) begin
      len <= prev_len;
      sym <= in_symbol;
    end else if ((state == S_CMP) && !cmp_done) begin
      len <= pre_rd;
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(MAX_LEN))
    else $error("position beyond capacity");

  a_len_below_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (POS_W'(len) < position))
    else $error("fallback length not below position");

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_set |-> (!res_valid || res_take))
    else $error("result overwritten before it was taken");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    cmp_done |=> (position == $past(position) + 1'b1))
    else $error("position did not advance after a stored symbol");
`endif

endmodule

>>> rtl/prefix_function_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_function_stream: online prefix function over a byte stream.
// Returns, per symbol, the longest proper border ending at that symbol.
// ----------------------------------------------------------------------------
// Each request on the s_axis side carries one symbol in tdata and a start
// flag in tuser that opens a new string. Exactly one result follows on the
// m_axis side for every request, in order: the border length in tdata and an
// overflow flag in tuser.
// The first symbol of a string, and any symbol once the string holds its
// full capacity, are answered from the idle state. Any other symbol goes to
// the compare state, which takes fallback steps until the symbol matches or
// the length reaches zero. Each step is one read of the symbol and prefix
// memories; the total of fallback steps never exceeds the string length.
// A new symbol is taken only in the idle state, once the last one is done.
// A finished result waits in the output register while the next request is
// taken; when the receiver stalls, one more result is held inside and then
// s_axis_tready drops until m_axis_tready returns.
// Reset empties both result slots and sets the position to zero, so the first
// symbol after reset starts a string. The memories need no clearing.
// ----------------------------------------------------------------------------
module prefix_function_stream
  import pfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] symbol
  input  logic                  s_axis_tuser,   // [0] start_req
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] prefix_len, rest zero
  output logic                  m_axis_tuser    // [0] overflow
);

  logic     res_valid;
  logic     res_take;
  pfs_res_t res;

  pfs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_symbol (s_axis_tdata[SYM_W-1:0]),
    .in_start  (s_axis_tuser),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // The output register refills in the same cycle that it is drained.
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= OUT_DATA_W'(res.prefix_len);
      m_axis_tuser <= res.overflow;
    end
  end

endmodule

>>> sim/prefix_function_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_function_stream_tb: self-checking bench for the prefix function.
// Streams strings of byte symbols into the block and predicts each border
// length. Every returned result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
// The run has two parts. A short directed list covers the first symbol
// after reset, extreme symbol values, repeated starts and
// fallbacks. Then come random strings under three idling patterns, with one
// long receiver hold-off. Strings are mostly periodic or use few letters, so
// that borders grow long and the fallback path gets real work.
// ----------------------------------------------------------------------------
module prefix_function_stream_tb;
  import pfs_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 170;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    sym_t sym;
    logic start;
  } symbol_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic                  s_axis_tuser = 1'b0; // [0] start_req
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [9:0] prefix_len, rest zero
  logic                  m_axis_tuser;        // [0] overflow

  symbol_req_t   pending_q[$];
  pfs_res_t      border_q[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic          in_taken = 1'b0;
  logic          hold_req = 1'b0;
  logic          recv_hold = 1'b0;

  // Predictor state: symbols and border lengths of the current string.
  sym_t          held_sym [MAX_LEN];
  int unsigned   held_border [MAX_LEN];
  int unsigned   held_len = 0;

  prefix_function_stream i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Extends the current string by one symbol and returns its border length.
  function automatic pfs_res_t extend_border(input sym_t sym, input logic start);
    pfs_res_t    res;
    int unsigned k;
    res = '0;
    if (start) held_len = 0;
    if (held_len >= MAX_LEN) begin
      res.overflow = 1'b1;
      return res;
    end
    k = 0;
    if (held_len > 0) begin
      k = held_border[held_len - 1];
      while (k > 0 && held_sym[k] != sym) k = held_border[k - 1];
      if (held_sym[k] == sym) k++;
    end
    held_sym[held_len]    = sym;
    held_border[held_len] = k;
    held_len++;
    res.prefix_len = k[PLEN_W-1:0];
    return res;
  endfunction

  task automatic push_item(input sym_t sym, input logic start);
    symbol_req_t req;
    req.sym   = sym;
    req.start = start;
    pending_q.push_back(req);
  endtask

  // Queues one string. Most are periodic or drawn from two or three letters;
  // a few are noise with scattered starts, and some do not open with a start.
  task automatic push_random_string(output int unsigned count);
    sym_t        letters [6];
    int unsigned kind;
    int unsigned len;
    int unsigned period;
    int unsigned alpha_size;
    logic        fresh;
    logic        start;
    sym_t        s;
    for (int i = 0; i < 6; i++) letters[i] = sym_t'($urandom);
    kind       = $urandom_range(9);
    len        = ($urandom_range(24) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
    period     = $urandom_range(6, 1);
    alpha_size = $urandom_range(3, 2);
    fresh      = ($urandom_range(9) != 0);
    for (int i = 0; i < len; i++) begin
      start = (i == 0) ? fresh : 1'b0;
      if (kind <= 5) begin
        s = letters[i % period];
        if ($urandom_range(19) == 0) s = letters[$urandom_range(5)];
      end else if (kind <= 8) begin
        s = letters[$urandom_range(alpha_size - 1)];
      end else begin
        s = sym_t'($urandom);
        if ($urandom_range(7) == 0) start = 1'b1;
      end
      push_item(s, start);
    end
    count = len;
  endtask

  // Holds until the sender has nothing left and every result has come back.
  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || border_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned queued;
    int unsigned n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      push_random_string(n);
      queued += n;
    end
    wait_drained();
  endtask

  // Sender: a request stays up until it is taken.
  always @(negedge clk) begin
    symbol_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.sym;
          s_axis_tuser  <= req.start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, timed on its own so the sender keeps pushing.
  initial begin
    wait (hold_req);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Monitor: results are checked before the request of the same edge is
  // predicted, since a result never leaves in the cycle its request enters.
  always @(posedge clk) begin
    pfs_res_t want;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("prefix_function_stream_tb: FAIL");
      $finish;
    end else if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (border_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%h/%b with no request outstanding",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = border_q.pop_front();
          if (m_axis_tdata !== {{(OUT_DATA_W-PLEN_W){1'b0}}, want.prefix_len}) begin
            report_mismatch($sformatf("prefix_len 0x%h, expected %0d",
                                      m_axis_tdata, want.prefix_len));
          end
          if (m_axis_tuser !== want.overflow) begin
            report_mismatch($sformatf("overflow %b, expected %b",
                                      m_axis_tuser, want.overflow));
          end
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        border_q.push_back(extend_border(s_axis_tdata, s_axis_tuser));
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: no start after reset, symbol extremes, a fallback step
    // on "aabaaab", a one-symbol string and back-to-back starts.
    send_idle_pct  = 7;
    recv_stall_pct = 45;
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hA5, 1'b1);
    push_item(8'hA5, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'h80, 1'b1);
    push_item(8'h80, 1'b1);
    push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'hFF, 1'b0);
    wait_drained();

    run_random_phase(7, 45);
    run_random_phase(45, 7);

    // The receiver holds off at the start of the last phase, so the block
    // fills and drops s_axis_tready while requests keep coming.
    hold_req = 1'b1;
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (border_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", border_q.size()));
    end
    if (error_count == 0) begin
      $display("prefix_function_stream_tb: PASS");
    end else begin
      $display("prefix_function_stream_tb: FAIL");
    end
    $finish;
  end

endmodule
